// ----- hw/rtl/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } bracket_kind_t;

  typedef struct packed {
    logic          is_open;
    logic          is_close;
    logic          is_alnum;
    logic          is_op;
    logic          is_space;
    bracket_kind_t kind;
  } char_class_t;

endpackage

// ----- hw/rtl/esc_in_if.sv -----
`timescale 1ns / 1ps

interface esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- hw/rtl/esc_out_if.sv -----
`timescale 1ns / 1ps

interface esc_out_if;
  logic valid;
  logic ready;
  logic expr_valid;

  modport source (output valid, output expr_valid, input ready);
  modport sink   (input valid, input expr_valid, output ready);
endinterface

// ----- hw/rtl/esc_ram.sv -----
`timescale 1ns / 1ps

module esc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/esc_char_decode.sv -----
`timescale 1ns / 1ps

module esc_char_decode (
  input  logic                 [7:0] char_code,
  output esc_pkg::char_class_t       cls
);

  always_comb begin
    cls          = '0;
    cls.kind     = esc_pkg::KIND_ROUND;
    cls.is_space = (char_code == esc_pkg::CH_SPACE);
    cls.is_alnum = (char_code >= esc_pkg::CH_DIG_LO && char_code <= esc_pkg::CH_DIG_HI) ||
                   (char_code >= esc_pkg::CH_UC_LO  && char_code <= esc_pkg::CH_UC_HI)  ||
                   (char_code >= esc_pkg::CH_LC_LO  && char_code <= esc_pkg::CH_LC_HI);
    unique case (char_code) inside
      esc_pkg::CH_LPAREN: begin
        cls.is_open = 1'b1;
        cls.kind    = esc_pkg::KIND_ROUND;
      end
      esc_pkg::CH_LBRACK: begin
        cls.is_open = 1'b1;
        cls.kind    = esc_pkg::KIND_SQUARE;
      end
      esc_pkg::CH_LBRACE: begin
        cls.is_open = 1'b1;
        cls.kind    = esc_pkg::KIND_CURLY;
      end
      esc_pkg::CH_RPAREN: begin
        cls.is_close = 1'b1;
        cls.kind     = esc_pkg::KIND_ROUND;
      end
      esc_pkg::CH_RBRACK: begin
        cls.is_close = 1'b1;
        cls.kind     = esc_pkg::KIND_SQUARE;
      end
      esc_pkg::CH_RBRACE: begin
        cls.is_close = 1'b1;
        cls.kind     = esc_pkg::KIND_CURLY;
      end
      esc_pkg::CH_PLUS, esc_pkg::CH_MINUS, esc_pkg::CH_STAR,
      esc_pkg::CH_SLASH, esc_pkg::CH_PCT: begin
        cls.is_op = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/expression_syntax_checker_top.sv -----
`timescale 1ns / 1ps
// Latency: the verdict appears in the output register the cycle after the last
// character's transfer. Throughput: one character per cycle while no verdict waits on a
// stalled output; a pop is served from the top-of-stack register while the RAM prefetches the entry below.
// Reset (synchronous, rst_n low): stack empty, counts and error cleared, output
// empty. No clearing pass: the stack RAM is only read below the current level.

module expression_syntax_checker_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  esc_in_if.sink           in_ch,
  esc_out_if.source        out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int CW = esc_pkg::CNT_W;

  logic                     in_xfer;
  esc_pkg::char_class_t     cls;

  logic [LW-1:0]            level_r, level_nxt;
  logic                     err_r, err_nxt;
  logic                     at_start_r;
  logic                     prev_op_r;
  logic [CW-1:0]            opnd_cnt_r, opnd_cnt_nxt;
  logic [CW-1:0]            oper_cnt_r, oper_cnt_nxt;
  esc_pkg::bracket_kind_t   tos_r, tos_nxt;
  logic                     out_valid_r;
  logic                     out_expr_r;
  logic                     verdict;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [1:0]               ram_rdata;

  esc_char_decode u_decode (
    .char_code (in_ch.char_code),
    .cls       (cls)
  );

  // ram_rdata always holds the entry just below the top (level_r - 2)
  esc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cls.kind),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    level_nxt    = level_r;
    err_nxt      = err_r;
    opnd_cnt_nxt = opnd_cnt_r;
    oper_cnt_nxt = oper_cnt_r;
    tos_nxt      = tos_r;
    ram_we       = 1'b0;
    ram_waddr    = level_r[AW-1:0];

    if (in_xfer) begin
      if (cls.is_op && (at_start_r || in_ch.is_last)) begin
        err_nxt = 1'b1;
      end
      if (cls.is_open) begin
        if (level_r == LW'(STACK_DEPTH)) begin
          err_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          tos_nxt   = cls.kind;
          level_nxt = level_r + LW'(1);
        end
      end else if (cls.is_close) begin
        if (level_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          level_nxt = level_r - LW'(1);
          tos_nxt   = esc_pkg::bracket_kind_t'(ram_rdata);
          if (tos_r != cls.kind) begin
            err_nxt = 1'b1;
          end
        end
      end else if (cls.is_alnum) begin
        if (opnd_cnt_r == esc_pkg::COUNT_MAX) begin
          err_nxt = 1'b1;
        end else begin
          opnd_cnt_nxt = opnd_cnt_r + CW'(1);
        end
      end else if (cls.is_op) begin
        if (oper_cnt_r == esc_pkg::COUNT_MAX) begin
          err_nxt = 1'b1;
        end else begin
          oper_cnt_nxt = oper_cnt_r + CW'(1);
        end
        if (!at_start_r && prev_op_r) begin
          err_nxt = 1'b1;
        end
      end else if (!cls.is_space) begin
        err_nxt = 1'b1;
      end
    end
  end

  // prefetch of the entry that a pop in the next cycle makes top-of-stack; wraps harmlessly below level 2
  assign ram_raddr = AW'(level_nxt - LW'(2));

  assign verdict = !err_nxt && (level_nxt == '0) &&
                   ({1'b0, opnd_cnt_nxt} == ({1'b0, oper_cnt_nxt} + (CW + 1)'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      err_r       <= 1'b0;
      at_start_r  <= 1'b1;
      prev_op_r   <= 1'b0;
      opnd_cnt_r  <= '0;
      oper_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        if (in_ch.is_last) begin
          level_r     <= '0;
          err_r       <= 1'b0;
          at_start_r  <= 1'b1;
          prev_op_r   <= 1'b0;
          opnd_cnt_r  <= '0;
          oper_cnt_r  <= '0;
          out_valid_r <= 1'b1;
        end else begin
          level_r     <= level_nxt;
          err_r       <= err_nxt;
          at_start_r  <= 1'b0;
          prev_op_r   <= cls.is_op;
          opnd_cnt_r  <= opnd_cnt_nxt;
          oper_cnt_r  <= oper_cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (in_xfer && in_ch.is_last) begin
      out_expr_r <= verdict;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.expr_valid = out_expr_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.is_last |=> level_r == '0 && at_start_r && !err_r &&
                                 opnd_cnt_r == '0 && oper_cnt_r == '0)
    else $error("state not cleared after last character");

  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_xfer && in_ch.is_last))
    else $error("verdict without a last character");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.is_last |-> !out_valid_r || out_ch.ready)
    else $error("pending verdict overwritten");

endmodule

// ----- bench/expression_syntax_checker_top_tb.sv -----
`timescale 1ns / 1ps

module expression_syntax_checker_top_tb;

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 8;

  logic clk;
  logic rst_n;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  expression_syntax_checker_top #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned chars_sent;
  int unsigned exprs_sent;
  int unsigned verdicts_checked;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          expected_verdict;
  bit          verdict_q[$];
  logic [7:0]  expr_buf[$];

  // checker state mirrored on the bench side
  esc_pkg::bracket_kind_t    open_kinds[DEPTH];
  int unsigned               open_level;
  bit                        syntax_err;
  logic [esc_pkg::CNT_W-1:0] n_operands;
  logic [esc_pkg::CNT_W-1:0] n_operators;
  logic [7:0]                prev_byte;
  bit                        first_byte;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_operator(input logic [7:0] c);
    return c == esc_pkg::CH_PLUS || c == esc_pkg::CH_MINUS || c == esc_pkg::CH_STAR ||
           c == esc_pkg::CH_SLASH || c == esc_pkg::CH_PCT;
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= esc_pkg::CH_DIG_LO && c <= esc_pkg::CH_DIG_HI) ||
           (c >= esc_pkg::CH_UC_LO && c <= esc_pkg::CH_UC_HI) ||
           (c >= esc_pkg::CH_LC_LO && c <= esc_pkg::CH_LC_HI);
  endfunction

  function automatic esc_pkg::bracket_kind_t bracket_kind(input logic [7:0] c);
    case (c)
      esc_pkg::CH_LBRACK, esc_pkg::CH_RBRACK: return esc_pkg::KIND_SQUARE;
      esc_pkg::CH_LBRACE, esc_pkg::CH_RBRACE: return esc_pkg::KIND_CURLY;
      default:                                return esc_pkg::KIND_ROUND;
    endcase
  endfunction

  function automatic logic [7:0] close_of(input logic [7:0] c);
    case (c)
      esc_pkg::CH_LPAREN: return esc_pkg::CH_RPAREN;
      esc_pkg::CH_LBRACK: return esc_pkg::CH_RBRACK;
      default:            return esc_pkg::CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] random_open();
    case ($urandom_range(0, 2))
      0:       return esc_pkg::CH_LPAREN;
      1:       return esc_pkg::CH_LBRACK;
      default: return esc_pkg::CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return esc_pkg::CH_PLUS;
      1:       return esc_pkg::CH_MINUS;
      2:       return esc_pkg::CH_STAR;
      3:       return esc_pkg::CH_SLASH;
      default: return esc_pkg::CH_PCT;
    endcase
  endfunction

  function automatic logic [7:0] random_alnum();
    int r = $urandom_range(0, 61);
    if (r < 10) return 8'(esc_pkg::CH_DIG_LO + r);
    if (r < 36) return 8'(esc_pkg::CH_UC_LO + (r - 10));
    return 8'(esc_pkg::CH_LC_LO + (r - 36));
  endfunction

  task automatic clear_checker_state();
    open_level  = 0;
    syntax_err  = 1'b0;
    n_operands  = '0;
    n_operators = '0;
    prev_byte   = '0;
    first_byte  = 1'b1;
  endtask

  task automatic bump_count(inout logic [esc_pkg::CNT_W-1:0] cnt);
    if (cnt == esc_pkg::COUNT_MAX) syntax_err = 1'b1;
    else cnt++;
  endtask

  // advance the mirrored state by one accepted character; on the last one, queue the verdict
  task automatic track_char(input logic [7:0] c, input bit last);
    if (is_operator(c) && (first_byte || last)) syntax_err = 1'b1;
    case (c)
      esc_pkg::CH_SPACE: ;
      esc_pkg::CH_LPAREN, esc_pkg::CH_LBRACK, esc_pkg::CH_LBRACE: begin
        if (open_level >= DEPTH) begin
          syntax_err = 1'b1;
        end else begin
          open_kinds[open_level] = bracket_kind(c);
          open_level++;
        end
      end
      esc_pkg::CH_RPAREN, esc_pkg::CH_RBRACK, esc_pkg::CH_RBRACE: begin
        if (open_level == 0) begin
          syntax_err = 1'b1;
        end else begin
          open_level--;
          if (open_kinds[open_level] != bracket_kind(c)) syntax_err = 1'b1;
        end
      end
      default: begin
        if (is_alnum(c)) begin
          bump_count(n_operands);
        end else if (is_operator(c)) begin
          bump_count(n_operators);
          // raw previous byte: a space in between breaks the run
          if (!first_byte && is_operator(prev_byte)) syntax_err = 1'b1;
        end else begin
          syntax_err = 1'b1;
        end
      end
    endcase
    prev_byte  = c;
    first_byte = 1'b0;
    if (last) begin
      verdict_q.push_back(!syntax_err && open_level == 0 &&
                          {1'b0, n_operands} == n_operators + 17'd1);
      clear_checker_state();
    end
  endtask

  // ready is sampled at the falling edge; nothing it depends on moves before the next rising edge
  task automatic send_char(input logic [7:0] c, input bit last);
    bit took;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last   <= last;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    chars_sent++;
    if (last) exprs_sent++;
    track_char(c, last);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
  endtask

  task automatic send_buf();
    foreach (expr_buf[i]) send_char(expr_buf[i], i == expr_buf.size() - 1);
  endtask

  task automatic add_space();
    if ($urandom_range(0, 5) == 0) expr_buf.push_back(esc_pkg::CH_SPACE);
  endtask

  task automatic add_term(input int nest);
    logic [7:0] opener;
    if (nest < 4 && $urandom_range(0, 3) == 0) begin
      opener = random_open();
      expr_buf.push_back(opener);
      add_space();
      add_expr(nest + 1);
      add_space();
      expr_buf.push_back(close_of(opener));
    end else begin
      expr_buf.push_back(random_alnum());
    end
  endtask

  task automatic add_expr(input int nest);
    int n_ops;
    add_term(nest);
    n_ops = $urandom_range(0, nest == 0 ? 4 : 2);
    repeat (n_ops) begin
      add_space();
      expr_buf.push_back(random_operator());
      add_space();
      add_term(nest);
    end
  endtask

  // mostly well-formed expressions, some damaged, some pure noise, a few nested around the stack top, some past it
  task automatic build_random_expr();
    int shape;
    int pos;
    int k;
    expr_buf = {};
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
    end else if (shape < 12) begin
      k = $urandom_range(DEPTH - 3, DEPTH + 2);
      repeat (k) expr_buf.push_back(random_open());
      expr_buf.push_back(random_alnum());
      for (int i = k - 1; i >= 0; i--) expr_buf.push_back(close_of(expr_buf[i]));
    end else begin
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(esc_pkg::CH_SPACE);
      add_expr(0);
      if ($urandom_range(0, 9) == 0) expr_buf.push_back(esc_pkg::CH_SPACE);
    end
    if (shape >= 8 && $urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, expr_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: expr_buf[pos] = 8'($urandom_range(0, 255));
        1: expr_buf.insert(pos, random_operator());
        2: if (expr_buf.size() > 1) expr_buf.delete(pos);
        default: expr_buf[pos] = $urandom_range(0, 1) ? random_open() : close_of(random_open());
      endcase
    end
  endtask

  task automatic test_basic_forms();
    send_text("a");
    send_text("{a+[b-c]}*(d/e%f)");
    send_text("+");
    send_text("a*-b");
    send_text(")");
    send_text("(]");
    send_text(" 7 ");
    expr_buf = '{8'h00, 8'hFF};
    send_buf();
  endtask

  // a completely full stack, then one opener past the top
  task automatic test_stack_limits();
    for (int k = DEPTH; k <= DEPTH + 1; k++) begin
      expr_buf = {};
      repeat (k) expr_buf.push_back(esc_pkg::CH_LBRACK);
      expr_buf.push_back("x");
      repeat (k) expr_buf.push_back(esc_pkg::CH_RBRACK);
      send_buf();
    end
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned n_chars);
    int unsigned stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      build_random_expr();
      send_buf();
    end
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

  // result check and stall watchdog; a transfer seen here completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict %0b with no expression pending", out_ch.expr_valid);
          fail_count++;
        end else begin
          expected_verdict = verdict_q.pop_front();
          if (out_ch.expr_valid !== expected_verdict) begin
            $error("expr_valid mismatch: expected %0b, actual %0b",
                   expected_verdict, out_ch.expr_valid);
            fail_count++;
          end
          verdicts_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("no transfer for %0d cycles, %0d verdicts outstanding",
                   quiet_cycles, verdict_q.size());
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.is_last   <= 1'b0;
    rst_n           <= 1'b0;
    src_idle_pct  = 25;
    sink_idle_pct = 58;
    clear_checker_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_forms();
    test_stack_limits();
    test_random_traffic(25, 58, 85);
    test_random_traffic(58, 25, 85);
    test_random_traffic(0, 0, 85);
    in_ch.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d characters in %0d expressions sent, %0d verdicts checked",
             chars_sent, exprs_sent, verdicts_checked);
    $display("covered all bracket kinds and operators, stack full and overflow,");
    $display("damaged and noise input, under three sender/receiver idle mixes");
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/esc_pkg.sv
hw/rtl/esc_in_if.sv
hw/rtl/esc_out_if.sv
hw/rtl/esc_ram.sv
hw/rtl/esc_char_decode.sv
hw/rtl/expression_syntax_checker_top.sv
bench/expression_syntax_checker_top_tb.sv
